// ----- src/lkr_pkg.sv -----
// lkr_pkg: field widths shared by the longest repeat window blocks
// no dependencies
`default_nettype none

package lkr_pkg;

    localparam int LETTER_W = 5;
    localparam int LEN_W    = 11;
    localparam int CFG_W    = 11;
    localparam int WIDE_W   = 9;

endpackage

`default_nettype wire

// ----- src/lkr_hist_ram.sv -----
// lkr_hist_ram: one write port, one read port letter history memory
// registered read data, no reset of contents; uses lkr_pkg for nothing beyond style
`default_nettype none

module lkr_hist_ram
    import lkr_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 5
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- src/longest_k_replace_repeat_window_unit.sv -----
// longest_k_replace_repeat_window_unit: streaming longest repeat window with k replacements
// depends on lkr_pkg and lkr_hist_ram
// an accepted item waits in the input register until the result register is free
// throughput: one item per cycle while results are taken, limited by the single compute stage between
// the input register and the result register
// reset: counts, window, position, best length and the register clear at once;
// the history memory is not cleared, no clearing pass
`default_nettype none

module longest_k_replace_repeat_window_unit
    import lkr_pkg::*;
#(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [CFG_W-1:0]   cfg_write_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [LETTER_W-1:0] letter,
    input  wire logic               first,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [LEN_W-1:0]   best_length,
    output logic                    overflow
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(ALPHABET);
    localparam int SW = ((PW > CFG_W) ? PW : CFG_W) + 1;
    localparam logic [WIDE_W-1:0] ALPHA_NUM  = WIDE_W'(ALPHABET);
    localparam logic [WIDE_W-1:0] ALPHA_LAST = WIDE_W'(ALPHABET - 1);
    localparam logic [PW-1:0]     LEN_LIMIT  = PW'(MAX_LEN);

    // configuration
    logic [CFG_W-1:0] k_reg;

    // input register
    logic                s1_valid_reg;
    logic [LETTER_W-1:0] s1_letter_reg;
    logic                s1_first_reg;

    // string state
    logic [PW-1:0] cnt_reg [ALPHABET];
    logic [PW-1:0] top_reg;
    logic [PW-1:0] ws_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] best_reg;

    // history prefetch
    logic          byp_reg;
    logic [CW-1:0] byp_data_reg;
    logic [CW-1:0] ram_rd_data;

    // result register
    logic             out_valid_reg;
    logic [LEN_W-1:0] out_best_reg;
    logic             out_ovf_reg;

    // compute stage
    logic                adv;
    logic [WIDE_W-1:0]   letter_wide;
    logic [WIDE_W-1:0]   ch_wide;
    logic [CW-1:0]       ch;
    logic [CW-1:0]       old;
    logic [PW-1:0]       cnt_eff [ALPHABET];
    logic [PW-1:0]       cnt_inc [ALPHABET];
    logic [PW-1:0]       cnt_next [ALPHABET];
    logic [PW-1:0]       top_eff;
    logic [PW-1:0]       ws_eff;
    logic [PW-1:0]       pos_eff;
    logic [PW-1:0]       best_eff;
    logic [PW-1:0]       ch_cnt_inc;
    logic [PW-1:0]       top_new;
    logic [PW-1:0]       len;
    logic [PW-1:0]       len_fin;
    logic [SW-1:0]       limit;
    logic                shrink;
    logic                ovf_now;
    logic [PW-1:0]       top_next;
    logic [PW-1:0]       ws_next;
    logic [PW-1:0]       pos_next;
    logic [PW-1:0]       best_next;
    logic [SW-1:0]       best_wide;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;

    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;

    assign letter_wide = WIDE_W'(s1_letter_reg);
    assign ch_wide     = (letter_wide >= ALPHA_NUM) ? ALPHA_LAST : letter_wide;
    assign ch          = ch_wide[CW-1:0];
    assign old         = byp_reg ? byp_data_reg : ram_rd_data;

    assign top_eff  = s1_first_reg ? '0 : top_reg;
    assign ws_eff   = s1_first_reg ? '0 : ws_reg;
    assign pos_eff  = s1_first_reg ? '0 : pos_reg;
    assign best_eff = s1_first_reg ? '0 : best_reg;

    assign ovf_now    = (pos_eff >= LEN_LIMIT);
    assign ch_cnt_inc = cnt_eff[ch] + PW'(1);
    assign top_new    = (ch_cnt_inc > top_eff) ? ch_cnt_inc : top_eff;
    assign len        = pos_eff - ws_eff + PW'(1);
    assign limit      = SW'(top_new) + SW'(k_reg);
    assign shrink     = (SW'(len) > limit) && (ws_eff < pos_eff);
    assign len_fin    = shrink ? (len - PW'(1)) : len;

    always_comb
    begin
        for (int i = 0; i < ALPHABET; i++)
        begin
            cnt_eff[i] = s1_first_reg ? '0 : cnt_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < ALPHABET; i++)
        begin
            cnt_inc[i] = cnt_eff[i] + PW'(CW'(i) == ch);
            if (shrink && (CW'(i) == old) && (cnt_inc[i] != '0))
            begin
                cnt_next[i] = cnt_inc[i] - PW'(1);
            end
            else
            begin
                cnt_next[i] = cnt_inc[i];
            end
        end
    end

    always_comb
    begin
        if (ovf_now)
        begin
            top_next  = top_eff;
            ws_next   = ws_eff;
            pos_next  = pos_eff;
            best_next = best_eff;
        end
        else
        begin
            top_next  = top_new;
            ws_next   = shrink ? (ws_eff + PW'(1)) : ws_eff;
            pos_next  = pos_eff + PW'(1);
            best_next = (len_fin > best_eff) ? len_fin : best_eff;
        end
    end

    assign best_wide = SW'(best_next);
    assign wr_en     = adv && !ovf_now;
    assign wr_addr   = pos_eff[AW-1:0];
    assign rd_addr   = adv ? ws_next[AW-1:0] : ws_reg[AW-1:0];

    lkr_hist_ram #(
        .DEPTH (MAX_LEN),
        .AW    (AW),
        .DW    (CW)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ch),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // the entry at the new window start may be the one written this cycle
    always_ff @(posedge clk)
    begin
        byp_data_reg <= ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            k_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_letter_reg <= letter;
            s1_first_reg  <= first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                cnt_reg[i] <= '0;
            end
            top_reg  <= '0;
            ws_reg   <= '0;
            pos_reg  <= '0;
            best_reg <= '0;
        end
        else if (adv)
        begin
            if (!ovf_now)
            begin
                for (int i = 0; i < ALPHABET; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
            top_reg  <= top_next;
            ws_reg   <= ws_next;
            pos_reg  <= pos_next;
            best_reg <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_best_reg <= best_wide[LEN_W-1:0];
            out_ovf_reg  <= ovf_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign best_length = out_best_reg;
    assign overflow    = out_ovf_reg;

    // window never starts past the write position
    assert property (@(posedge clk) disable iff (!rst_n) ws_reg <= pos_reg)
        else $error("window start beyond position");

    // highest count and best length are bounded by the string length
    assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg <= pos_reg) && (best_reg <= pos_reg))
        else $error("count or best length beyond position");

    // an ignored letter leaves the string state alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && ovf_now && !s1_first_reg) |=> ($stable(pos_reg) && $stable(ws_reg)))
        else $error("state changed on overflow");

    // a held result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !adv)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ----- bench/lkr_window_checker.sv -----
`timescale 1ns / 1ps
// lkr_window_checker: watches the letter and result channels of the repeat window unit,
// predicts each item's best window length and overflow flag, and counts mismatches
// depends on lkr_pkg
module lkr_window_checker
    import lkr_pkg::*;
#(
    parameter int MAX_LEN  = 1024,
    parameter int ALPHABET = 26
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [CFG_W-1:0]    cfg_write_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [LETTER_W-1:0] letter,
    input  logic                first,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [LEN_W-1:0]    best_length,
    input  logic                overflow,
    output int                  error_count,
    output int                  outstanding
);

    typedef struct packed {
        logic [LEN_W-1:0] best_length;
        logic             overflow;
    } window_result_t;

    window_result_t window_results_q [$];

    logic [LETTER_W-1:0] letter_log [MAX_LEN];
    int unsigned         letter_tally [ALPHABET];
    int unsigned         peak_tally;
    int unsigned         win_start;
    int unsigned         str_pos;
    int unsigned         best_len;
    int unsigned         replace_limit;

    function automatic void clear_string();
        foreach (letter_tally[i])
            letter_tally[i] = 0;
        peak_tally = 0;
        win_start  = 0;
        str_pos    = 0;
        best_len   = 0;
    endfunction

    function automatic window_result_t predict_window(input logic [LETTER_W-1:0] raw,
                                                      input logic fresh);
        window_result_t r;
        int unsigned    ch;
        int unsigned    len;
        int unsigned    old;
        ch = (32'(raw) >= ALPHABET) ? ALPHABET - 1 : 32'(raw);
        if (fresh)
            clear_string();
        r.overflow = 1'b0;
        if (str_pos >= MAX_LEN)
        begin
            r.overflow = 1'b1;
        end
        else
        begin
            letter_log[str_pos] = LETTER_W'(ch);
            letter_tally[ch]++;
            if (letter_tally[ch] > peak_tally)
                peak_tally = letter_tally[ch];
            len = str_pos - win_start + 1;
            if (len > peak_tally + replace_limit && win_start < str_pos)
            begin
                old = 32'(letter_log[win_start]);
                if (old >= ALPHABET)
                    old = ALPHABET - 1;
                if (letter_tally[old] > 0)
                    letter_tally[old]--;
                win_start++;
                len--;
            end
            if (len > best_len)
                best_len = len;
            str_pos++;
        end
        r.best_length = LEN_W'(best_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t want;
        if (!rst_n)
        begin
            clear_string();
            replace_limit = 0;
            window_results_q.delete();
            error_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_write_en)
                replace_limit = 32'(cfg_write_data);
            if (out_valid && out_ready)
            begin
                if (window_results_q.size() == 0)
                begin
                    $error("result item with no letter pending: best_length %0d overflow %0d",
                           best_length, overflow);
                    error_count++;
                end
                else
                begin
                    want = window_results_q.pop_front();
                    if (best_length !== want.best_length)
                    begin
                        $error("best_length: expected %0d, actual %0d",
                               want.best_length, best_length);
                        error_count++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, actual %0d", want.overflow, overflow);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                window_results_q.push_back(predict_window(letter, first));
            outstanding = window_results_q.size();
        end
    end

endmodule

// ----- bench/tb_longest_k_replace_repeat_window_unit.sv -----
`timescale 1ns / 1ps
// tb_longest_k_replace_repeat_window_unit: drives letter strings and replacement limits
// into the repeat window unit with random gaps and stalls; lkr_window_checker judges results
// depends on lkr_pkg, longest_k_replace_repeat_window_unit and lkr_window_checker
module tb_longest_k_replace_repeat_window_unit;
    import lkr_pkg::*;

    localparam int MAX_LEN = 1024;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [CFG_W-1:0]    cfg_write_data;
    logic                in_valid;
    logic                in_ready;
    logic [LETTER_W-1:0] letter;
    logic                first;
    logic                out_valid;
    logic                out_ready;
    logic [LEN_W-1:0]    best_length;
    logic                overflow;

    int error_count;
    int outstanding;
    int items_sent;
    bit steady;
    bit held_off;

    longest_k_replace_repeat_window_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .letter         (letter),
        .first          (first),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .best_length    (best_length),
        .overflow       (overflow)
    );

    lkr_window_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .letter         (letter),
        .first          (first),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .best_length    (best_length),
        .overflow       (overflow),
        .error_count    (error_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 50);
    endfunction

    task automatic send_item(input logic [LETTER_W-1:0] l, input logic f);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        letter   <= l;
        first    <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic set_limit(input int unsigned k);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= CFG_W'(k);
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    task automatic send_string(input int unsigned count, input bit fresh);
        int unsigned         span;
        logic [LETTER_W-1:0] l;
        span = ($urandom_range(0, 3) == 0) ? 26 : $urandom_range(1, 4);
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                l = LETTER_W'($urandom_range(0, 31));
            else
                l = LETTER_W'($urandom_range(0, span - 1));
            send_item(l, (fresh && i == 0) || ($urandom_range(0, 99) == 0));
        end
    endtask

    // receiver: random ready pattern with one long hold-off
    initial
    begin
        int gap;
        out_ready = 1'b0;
        held_off  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && items_sent >= 150)
            begin
                held_off = 1'b1;
                gap = 100;
            end
            else
            begin
                gap = pick_gap();
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    initial
    begin
        int unsigned k_plan [8] = '{0, 1024, 1, 2, 3, 0, 7, 1024};
        int unsigned k;
        int          phase_end;
        int unsigned len;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        letter         = '0;
        first          = 1'b0;
        items_sent     = 0;
        steady         = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no first flag after reset, limit still zero
        send_item(5'd0, 1'b0);
        send_item(5'd0, 1'b0);
        send_item(5'd1, 1'b0);
        send_item(5'd25, 1'b0);
        send_item(5'd31, 1'b0);
        send_item(5'd26, 1'b0);
        send_item(5'd0, 1'b1);
        send_item(5'd21, 1'b0);
        send_item(5'd10, 1'b0);
        send_item(5'd21, 1'b0);
        send_item(5'd2, 1'b0);
        set_limit(1024);
        send_item(5'd3, 1'b1);
        send_item(5'd4, 1'b0);
        send_item(5'd5, 1'b0);
        send_item(5'd30, 1'b0);

        for (int p = 0; p < 8; p++)
        begin
            k = (p == 6) ? $urandom_range(0, 12) : k_plan[p];
            set_limit(k);
            if (p == 1)
            begin
                // full-length string, ignored letters past the end, then restart
                steady = 1'b0;
                send_item(LETTER_W'($urandom_range(0, 2)), 1'b1);
                for (int i = 1; i < MAX_LEN + 6; i++)
                    send_item(LETTER_W'($urandom_range(0, 2)), 1'b0);
                send_item(LETTER_W'($urandom_range(0, 25)), 1'b1);
            end
            phase_end = items_sent + 90;
            while (items_sent < phase_end)
            begin
                steady = ($urandom_range(0, 3) == 0);
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom_range(17, 60);
                send_string(len, $urandom_range(0, 9) != 0);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- longest_k_replace_repeat_window_unit.f -----
src/lkr_pkg.sv
src/lkr_hist_ram.sv
src/longest_k_replace_repeat_window_unit.sv
bench/lkr_window_checker.sv
bench/tb_longest_k_replace_repeat_window_unit.sv
